FILE: rtl/core/bdr_pkg.sv
// Shared types and constants of the byte delta RGBA decoder.
`timescale 1ns / 1ps
`default_nettype none
package bdr_pkg;

  // Parse phase of the command front end, one-hot
  typedef enum logic [3:0] {
    PH_CMD     = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_SKIP_LO = 4'b0100,
    PH_SKIP_HI = 4'b1000
  } phase_t;

  // Command byte codes
  localparam logic [7:0] CMD_NEXT_CHAN  = 8'd0;
  localparam logic [7:0] CMD_SKIP_FIRST = 8'd1;
  localparam logic [7:0] CMD_SKIP_LAST  = 8'd62;
  localparam logic [7:0] CMD_SKIP_LONG  = 8'd63;
  localparam logic [7:0] CMD_END        = 8'd64;
  localparam int         RUN_FLAG_BIT   = 7;

  // Result kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 3;
  localparam logic [2:0] CFG_ROW_PITCH   = 3'd0;
  localparam logic [2:0] CFG_PREC_RED    = 3'd1;
  localparam logic [2:0] CFG_PREC_GREEN  = 3'd2;
  localparam logic [2:0] CFG_PREC_BLUE   = 3'd3;
  localparam logic [2:0] CFG_PREC_ALPHA  = 3'd4;
  localparam int         CFG_DATA_W      = 17;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Delta width codes: 1, 2, 4 or 8 bits
  localparam logic [1:0] WIDTH_1 = 2'd0;
  localparam logic [1:0] WIDTH_2 = 2'd1;
  localparam logic [1:0] WIDTH_4 = 2'd2;
  localparam logic [1:0] WIDTH_8 = 2'd3;

  // Configuration seen by the front end
  typedef struct packed {
    logic signed [16:0] row_pitch;
    logic [3:0][3:0]    prec;
  } cfg_t;

  // One queued job: a run data byte or an end marker
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] cnt_m1;   // number of updates minus one
    logic [1:0] wcode;
    logic       sub;
    logic [4:0] shift;
  } job_t;

endpackage
`default_nettype wire

FILE: rtl/core/bdr_front.sv
// Parser: tracks channel, row and offset; queues update and end jobs.
`timescale 1ns / 1ps
`default_nettype none
module bdr_front #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,
  input  wire bdr_pkg::cfg_t        cfg,
  input  wire logic                 q_full,
  output logic                      q_push,
  output bdr_pkg::job_t             q_job,
  output logic [ADDR_BITS-1:0]      q_addr
);

  bdr_pkg::phase_t       phase_r, phase_nxt;
  logic [4:0]            deltas_left_r, deltas_left_nxt;
  logic [2:0]            run_mode_r, run_mode_nxt;
  logic [1:0]            chan_r, chan_nxt;
  logic [ADDR_BITS-1:0]  row_base_r, row_base_nxt;
  logic [ADDR_BITS-1:0]  pix_off_r, pix_off_nxt;
  logic [7:0]            skip_lo_r, skip_lo_nxt;

  logic                  in_fire;
  logic [4:0]            per_byte;
  logic [4:0]            n_emit;
  logic [1:0]            chan_inc;
  logic [3:0]            prec_cur;
  logic [4:0]            shift_cur;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && !q_full;

  // Updates this data byte yields
  assign per_byte  = 5'd8 >> run_mode_r[1:0];
  assign n_emit    = (deltas_left_r < per_byte) ? deltas_left_r : per_byte;
  assign chan_inc  = chan_r + 2'd1;
  assign prec_cur  = cfg.prec[chan_r];
  assign shift_cur = 5'd8 - {1'b0, prec_cur};

  // Parse one request
  always_comb begin
    phase_nxt       = phase_r;
    deltas_left_nxt = deltas_left_r;
    run_mode_nxt    = run_mode_r;
    chan_nxt        = chan_r;
    row_base_nxt    = row_base_r;
    pix_off_nxt     = pix_off_r;
    skip_lo_nxt     = skip_lo_r;
    q_push          = 1'b0;
    q_job           = '0;
    q_addr          = row_base_r + pix_off_r;
    if (in_fire) begin
      case (phase_r)
        bdr_pkg::PH_DATA: begin
          q_push          = 1'b1;
          q_job.kind      = bdr_pkg::KIND_UPDATE;
          q_job.data      = in_tdata;
          q_job.cnt_m1    = 3'(n_emit - 5'd1);
          q_job.wcode     = run_mode_r[1:0];
          q_job.sub       = run_mode_r[2];
          q_job.shift     = shift_cur;
          pix_off_nxt     = pix_off_r + ADDR_BITS'({n_emit, 2'b00});
          deltas_left_nxt = deltas_left_r - n_emit;
          if (deltas_left_nxt == 5'd0) begin
            phase_nxt = bdr_pkg::PH_CMD;
          end
        end
        bdr_pkg::PH_SKIP_LO: begin
          skip_lo_nxt = in_tdata;
          phase_nxt   = bdr_pkg::PH_SKIP_HI;
        end
        bdr_pkg::PH_SKIP_HI: begin
          pix_off_nxt = pix_off_r + ADDR_BITS'({in_tdata, skip_lo_r, 2'b00});
          phase_nxt   = bdr_pkg::PH_CMD;
        end
        bdr_pkg::PH_CMD: begin
          if (in_tdata[bdr_pkg::RUN_FLAG_BIT]) begin
            deltas_left_nxt = {1'b0, in_tdata[3:0]} + 5'd1;
            run_mode_nxt    = in_tdata[6:4];
            phase_nxt       = bdr_pkg::PH_DATA;
          end else if (in_tdata == bdr_pkg::CMD_NEXT_CHAN) begin
            // wrap to channel 0 moves down one row
            chan_nxt    = chan_inc;
            if (chan_inc == 2'd0) begin
              row_base_nxt = row_base_r + ADDR_BITS'(cfg.row_pitch);
            end
            pix_off_nxt = ADDR_BITS'(chan_inc);
          end else if (in_tdata == bdr_pkg::CMD_SKIP_LONG) begin
            phase_nxt = bdr_pkg::PH_SKIP_LO;
          end else if (in_tdata inside {[bdr_pkg::CMD_SKIP_FIRST:bdr_pkg::CMD_SKIP_LAST]}) begin
            pix_off_nxt = pix_off_r + ADDR_BITS'({in_tdata, 2'b00});
          end else if (in_tdata == bdr_pkg::CMD_END) begin
            phase_nxt       = bdr_pkg::PH_CMD;
            deltas_left_nxt = 5'd0;
            run_mode_nxt    = 3'd0;
            chan_nxt        = 2'd0;
            row_base_nxt    = '0;
            pix_off_nxt     = '0;
            skip_lo_nxt     = 8'd0;
            q_push          = 1'b1;
            q_job.kind      = bdr_pkg::KIND_END;
            q_addr          = '0;
          end
        end
        default: begin
          phase_nxt = bdr_pkg::PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= bdr_pkg::PH_CMD;
      deltas_left_r <= 5'd0;
      run_mode_r    <= 3'd0;
      chan_r        <= 2'd0;
      row_base_r    <= '0;
      pix_off_r     <= '0;
      skip_lo_r     <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      deltas_left_r <= deltas_left_nxt;
      run_mode_r    <= run_mode_nxt;
      chan_r        <= chan_nxt;
      row_base_r    <= row_base_nxt;
      pix_off_r     <= pix_off_nxt;
      skip_lo_r     <= skip_lo_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bdr_queue.sv
// Short job queue between the parser and the update generator.
`timescale 1ns / 1ps
`default_nettype none
module bdr_queue #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire bdr_pkg::job_t         push_job,
  input  wire logic [ADDR_BITS-1:0]  push_addr,
  input  wire logic                  pop,
  output logic                       full,
  output logic                       empty,
  output bdr_pkg::job_t              head_job,
  output logic [ADDR_BITS-1:0]       head_addr
);

  bdr_pkg::job_t               job_q   [bdr_pkg::QUEUE_DEPTH];
  logic [ADDR_BITS-1:0]        addr_q  [bdr_pkg::QUEUE_DEPTH];
  logic [bdr_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bdr_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bdr_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign full      = (count_r == (bdr_pkg::QUEUE_AW + 1)'(bdr_pkg::QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_job  = job_q[rd_ptr_r];
  assign head_addr = addr_q[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      job_q[wr_ptr_r]  <= push_job;
      addr_q[wr_ptr_r] <= push_addr;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bdr_back.sv
// Job delta unpacker: one result per cycle unless output stalls.
`timescale 1ns / 1ps
`default_nettype none
module bdr_back #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_empty,
  input  wire bdr_pkg::job_t         q_job,
  input  wire logic [ADDR_BITS-1:0]  q_addr,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic                       out_kind,
  output logic [31:0]                out_addr,
  output logic [7:0]                 out_delta,
  output logic                       out_sub,
  output logic                       out_last
);

  logic [2:0]            k_r, k_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic                  out_kind_r;
  logic [31:0]           out_addr_r;
  logic [7:0]            out_delta_r;
  logic                  out_sub_r;
  logic                  out_last_r;

  logic                  emit;
  logic                  last;
  logic [2:0]            bit_pos;
  logic [7:0]            shifted;
  logic [7:0]            fmask;
  logic [8:0]            val9;
  logic [7:0]            delta;
  logic [ADDR_BITS-1:0]  addr;

  assign emit  = !q_empty && (!out_tvalid_r || out_tready);
  assign last  = q_job.kind || (k_r == q_job.cnt_m1);
  assign q_pop = emit && last;

  // Select the k-th delta field of the data byte
  assign bit_pos = 3'(k_r << q_job.wcode);
  assign shifted = q_job.data >> bit_pos;

  always_comb begin
    case (q_job.wcode)
      bdr_pkg::WIDTH_1: fmask = 8'h01;
      bdr_pkg::WIDTH_2: fmask = 8'h03;
      bdr_pkg::WIDTH_4: fmask = 8'h0F;
      default:          fmask = 8'hFF;
    endcase
  end

  // (v + 1) << shift, truncated to a byte; 0 for end or shift >= 8
  assign val9 = {1'b0, shifted & fmask} + 9'd1;
  always_comb begin
    if (q_job.kind || (q_job.shift[4:3] != 2'd0)) begin
      delta = 8'd0;
    end else begin
      delta = 8'(val9 << q_job.shift[2:0]);
    end
  end

  assign addr = q_addr + ADDR_BITS'({k_r, 2'b00});

  // Field index and output register control
  always_comb begin
    k_nxt          = k_r;
    out_tvalid_nxt = out_tvalid_r;
    if (emit) begin
      k_nxt          = last ? 3'd0 : k_r + 3'd1;
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r          <= 3'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= q_job.kind;
      out_addr_r  <= 32'(addr);
      out_delta_r <= delta;
      out_sub_r   <= q_job.sub;
      out_last_r  <= last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_kind   = out_kind_r;
  assign out_addr   = out_addr_r;
  assign out_delta  = out_delta_r;
  assign out_sub    = out_sub_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

FILE: rtl/core/byte_delta_rgba_decoder.sv
// Top level of the byte delta RGBA decoder: config registers and datapath.
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  tdata: stream byte
//  out_     master     out_tvalid/tready    tdata: address, delta, subtract;
//                                           tuser: kind; tlast: last of byte
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The parser takes one stream byte per cycle while its 4-entry job queue has
// room. The update generator drains a job at one result per cycle while the
// output is not stalled; a data byte of 1-bit deltas yields up to 8 results.
// Reset (rst_n low, synchronous) clears parse state, queue and output valid;
// configuration returns to pitch 0 and precision 8. A stalled output holds
// its result while the parser keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none
module byte_delta_rgba_decoder #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] stream_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [31:0] byte_address, [39:32] delta_value, [40] subtract, [47:41] zero
  output logic [47:0]                        out_tdata,
  output logic                               out_tuser,  // [0] item_kind
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic signed [16:0] row_pitch_r;
  logic [3:0][3:0]    prec_r;
  bdr_pkg::cfg_t      cfg;

  logic                  q_full, q_empty, q_push, q_pop;
  bdr_pkg::job_t         push_job, head_job;
  logic [ADDR_BITS-1:0]  push_addr, head_addr;

  logic [31:0]           res_addr;
  logic [7:0]            res_delta;
  logic                  res_sub;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r <= 17'sd0;
      prec_r      <= {4{4'd8}};
    end else if (cfg_valid) begin
      case (cfg_index)
        bdr_pkg::CFG_ROW_PITCH:  row_pitch_r <= cfg_data;
        bdr_pkg::CFG_PREC_RED:   prec_r[0]   <= cfg_data[3:0];
        bdr_pkg::CFG_PREC_GREEN: prec_r[1]   <= cfg_data[3:0];
        bdr_pkg::CFG_PREC_BLUE:  prec_r[2]   <= cfg_data[3:0];
        bdr_pkg::CFG_PREC_ALPHA: prec_r[3]   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg.row_pitch = row_pitch_r;
  assign cfg.prec      = prec_r;

  bdr_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job),
    .q_addr    (push_addr)
  );

  bdr_queue #(.ADDR_BITS(ADDR_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .push_addr (push_addr),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head_job  (head_job),
    .head_addr (head_addr)
  );

  bdr_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .q_addr     (head_addr),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_addr   (res_addr),
    .out_delta  (res_delta),
    .out_sub    (res_sub),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, res_sub, res_delta, res_addr};

endmodule
`default_nettype wire
